@@ rtl/core/wind_speed_from_sensor_voltages_assert.svh @@
// Assertion macros shared by the RTL. They sample on aclk and hold off while aresetn is low.
`ifndef WIND_SPEED_FROM_SENSOR_VOLTAGES_ASSERT_SVH
`define WIND_SPEED_FROM_SENSOR_VOLTAGES_ASSERT_SVH
`ifndef SYNTHESIS
`define WSFSV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WSFSV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WSFSV_ASSERT_IMPL(lbl, ante, cons)
`define WSFSV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/wsfsv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wsfsv_pkg;

    localparam int LOG_TABLE_BITS = 8;
    localparam int TAB_N = 1 << LOG_TABLE_BITS;
    localparam int FRAC_SH = 30 - LOG_TABLE_BITS;
    localparam int LOG_W = 37;

    localparam longint unsigned LN2_Q30 = 64'd744261118;
    localparam longint EXPT_Q24 = ((64'd115157 << 24) + 64'd500000) / 64'd1000000;
    localparam longint EXPW_Q24 = ((64'd3009364 << 24) + 64'd500000) / 64'd1000000;
    localparam logic signed [22:0] EXPT_S = 23'(EXPT_Q24);
    localparam logic signed [26:0] EXPW_S = 27'(EXPW_Q24);
    localparam logic [23:0] SPEED_MAX = 24'hFFFFFF;
    localparam logic [26:0] RECIP_39 = 27'd110127367;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_OFFSET = 2'd1,
        ST_TEMP   = 2'd2,
        ST_SAT    = 2'd3
    } status_t;

    typedef logic [31:0] rom_t [0:TAB_N];

    function automatic longint log2_exact(longint unsigned x);
        longint unsigned t;
        longint unsigned m;
        longint unsigned fr;
        int e;
        e = 0;
        t = x;
        while (t > 64'd1) begin
            t = t >> 1;
            e = e + 1;
        end
        m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
        fr = 64'd0;
        for (int k = 0; k < 30; k++) begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                fr = fr | 64'd1;
            end
        end
        return longint'(e) * (longint'(1) << 30) + longint'(fr);
    endfunction

    function automatic longint unsigned udiv_const(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic rom_t build_log_rom();
        rom_t r;
        longint v;
        for (int i = 0; i <= TAB_N; i++) begin
            v = log2_exact(longint'(TAB_N + i)) - longint'(LOG_TABLE_BITS) * (longint'(1) << 30);
            r[i] = 32'(v);
        end
        return r;
    endfunction

    function automatic rom_t build_exp_rom();
        rom_t r;
        longint unsigned x;
        longint unsigned sum;
        longint unsigned term;
        for (int i = 0; i <= TAB_N; i++) begin
            x = (longint'(i) * LN2_Q30) >> LOG_TABLE_BITS;
            sum = 64'd1 << 30;
            term = 64'd1 << 30;
            for (int k = 1; k <= 24; k++) begin
                term = udiv_const((term * x) >> 30, longint'(k));
                sum = sum + term;
            end
            r[i] = 32'(sum);
        end
        r[TAB_N] = 32'h8000_0000;
        return r;
    endfunction

    localparam rom_t LOG_ROM = build_log_rom();
    localparam rom_t EXP_ROM = build_exp_rom();

    localparam logic signed [LOG_W-1:0] C_LOG1000 = LOG_W'(log2_exact(64'd1000));
    localparam logic signed [LOG_W-1:0] C_LOG39 = LOG_W'(log2_exact(64'd39));
    localparam logic signed [LOG_W-1:0] C_LOGK = LOG_W'(log2_exact(64'd3038517)
        + log2_exact(64'd87288) - log2_exact(64'd1000000000000));

    function automatic logic [3:0] msb_pos(logic [13:0] x);
        logic [3:0] e;
        e = 4'd0;
        for (int i = 0; i < 14; i++) begin
            if (x[i]) begin
                e = 4'(i);
            end
        end
        return e;
    endfunction

    function automatic logic [29:0] norm_frac(logic [13:0] x, logic [3:0] e);
        logic [43:0] w;
        w = {30'd0, x} << (6'd30 - {2'd0, e});
        return w[29:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/wind_speed_from_sensor_voltages.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while a finished result waits on m_ready.
// Reset (aresetn low, synchronous) clears all valid bits; data registers keep
// their contents.
`include "wind_speed_from_sensor_voltages_assert.svh"
module wind_speed_from_sensor_voltages
    import wsfsv_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [11:0]        s_vout_code,
    input  wire logic [11:0]        s_vtemp_code,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [13:0]      m_temperature,
    output logic [23:0]             m_wind_speed,
    output logic [1:0]              m_status
);

    localparam int NSTAGE = 11;

    logic              adv;
    logic [NSTAGE-1:0] vld_reg;

    // stage 1
    logic [13:0]              xv, xt;
    logic [3:0]               ev_next, et_next;
    logic [29:0]              frv, frt;
    logic [17:0]              tnum_next;
    logic                     tneg_next;
    status_t                  st_next;
    logic [17:0]              tnum_reg;
    logic                     tneg_reg;
    logic [3:0]               ev_reg, et_reg;
    logic [LOG_TABLE_BITS-1:0] idxv_reg, idxt_reg;
    logic [FRAC_SH-1:0]       remv_reg, remt_reg;

    // stage 2
    logic [LOG_TABLE_BITS:0]  idxv1, idxt1;
    logic [31:0]              lov2_reg, dv2_reg, lot2_reg, dt2_reg;
    logic [FRAC_SH-1:0]       remv2_reg, remt2_reg;
    logic [3:0]               ev2_reg, et2_reg;
    logic [44:0]              tprod_reg;
    logic                     tneg2_reg;

    // stage 3
    logic [32+FRAC_SH-1:0]    pv, pt;
    logic [12:0]              tq;
    logic [13:0]              t16_next;
    logic [31:0]              lov3_reg, fv3_reg, lot3_reg, ft3_reg;
    logic [3:0]               ev3_reg, et3_reg;

    // stage 4..7
    logic signed [LOG_W-1:0]  lv_next, lt_next, lv4_reg, lt4_reg;
    logic signed [59:0]       ptl_next, ptl5_reg;
    logic signed [LOG_W-1:0]  lvk5_reg, a_next, a6_reg;
    logic signed [63:0]       pa_next, pa7_reg;

    // stage 8..10
    logic signed [39:0]       y;
    logic signed [9:0]        ip, sfull;
    logic [LOG_TABLE_BITS-1:0] eidx;
    logic [LOG_TABLE_BITS:0]  eidx1;
    logic [31:0]              elo8_reg, ed8_reg;
    logic [FRAC_SH-1:0]       erem8_reg;
    logic [4:0]               s8_reg, s9_reg, s10_reg;
    logic                     sat8_reg, sat9_reg, sat10_reg;
    logic                     live8_reg, live9_reg, live10_reg;
    logic [32+FRAC_SH-1:0]    pe;
    logic [31:0]              elo9_reg, ef9_reg, v10_reg;

    // carried fields
    status_t                  st_pipe_reg [1:10];
    logic [13:0]              t16_pipe_reg [3:10];

    // output
    logic [32:0]              rnd;
    logic [23:0]              speed_next;
    status_t                  status_next;
    logic signed [13:0]       m_temperature_reg;
    logic [23:0]              m_wind_speed_reg;
    status_t                  m_status_reg;

    assign adv = !vld_reg[NSTAGE-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NSTAGE-1];
    assign m_temperature = m_temperature_reg;
    assign m_wind_speed = m_wind_speed_reg;
    assign m_status = m_status_reg;

    always_comb begin
        xv = {1'b0, s_vout_code, 1'b0} - 14'd1253;
        xt = {s_vtemp_code, 2'b00} - 14'd800;
        ev_next = msb_pos(xv);
        et_next = msb_pos(xt);
        frv = norm_frac(xv, ev_next);
        frt = norm_frac(xt, et_next);
        tneg_next = s_vtemp_code < 12'd200;
        if (tneg_next) begin
            tnum_next = 18'd12800 - {s_vtemp_code, 6'd0} + 18'd19;
        end else begin
            tnum_next = {s_vtemp_code, 6'd0} - 18'd12800 + 18'd19;
        end
        if (s_vtemp_code <= 12'd200) begin
            st_next = ST_TEMP;
        end else if (s_vout_code <= 12'd626) begin
            st_next = ST_OFFSET;
        end else begin
            st_next = ST_OK;
        end
    end

    always_comb begin
        idxv1 = {1'b0, idxv_reg} + 1'b1;
        idxt1 = {1'b0, idxt_reg} + 1'b1;
        pv = dv2_reg * remv2_reg;
        pt = dt2_reg * remt2_reg;
        tq = tprod_reg[44:32];
        t16_next = tneg2_reg ? (14'd0 - {1'b0, tq}) : {1'b0, tq};
        lv_next = $signed({3'd0, ev3_reg, 30'd0}) + $signed({5'd0, lov3_reg})
                  + $signed({5'd0, fv3_reg}) - C_LOG1000;
        lt_next = $signed({3'd0, et3_reg, 30'd0}) + $signed({5'd0, lot3_reg})
                  + $signed({5'd0, ft3_reg}) - C_LOG39;
        ptl_next = lt4_reg * EXPT_S;
        a_next = lvk5_reg - LOG_W'(ptl5_reg >>> 24);
        pa_next = a6_reg * EXPW_S;
        y = 40'(pa7_reg >>> 24) + 40'sd8589934592;
        ip = y[39:30];
        sfull = 10'sd30 - ip;
        eidx = y[29:FRAC_SH];
        eidx1 = {1'b0, eidx} + 1'b1;
        pe = ed8_reg * erem8_reg;
        rnd = ({1'b0, v10_reg} + (33'd1 << (s10_reg - 5'd1))) >> s10_reg;
        speed_next = 24'd0;
        status_next = st_pipe_reg[10];
        if (st_pipe_reg[10] == ST_OK) begin
            if (sat10_reg || (live10_reg && rnd > {9'd0, SPEED_MAX})) begin
                speed_next = SPEED_MAX;
                status_next = ST_SAT;
            end else if (live10_reg) begin
                speed_next = rnd[23:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tnum_reg <= tnum_next;
            tneg_reg <= tneg_next;
            ev_reg <= ev_next;
            et_reg <= et_next;
            idxv_reg <= frv[29:FRAC_SH];
            idxt_reg <= frt[29:FRAC_SH];
            remv_reg <= frv[FRAC_SH-1:0];
            remt_reg <= frt[FRAC_SH-1:0];
            st_pipe_reg[1] <= st_next;

            lov2_reg <= LOG_ROM[idxv_reg];
            dv2_reg <= LOG_ROM[idxv1] - LOG_ROM[idxv_reg];
            lot2_reg <= LOG_ROM[idxt_reg];
            dt2_reg <= LOG_ROM[idxt1] - LOG_ROM[idxt_reg];
            remv2_reg <= remv_reg;
            remt2_reg <= remt_reg;
            ev2_reg <= ev_reg;
            et2_reg <= et_reg;
            tprod_reg <= tnum_reg * RECIP_39;
            tneg2_reg <= tneg_reg;

            lov3_reg <= lov2_reg;
            fv3_reg <= pv[FRAC_SH +: 32];
            lot3_reg <= lot2_reg;
            ft3_reg <= pt[FRAC_SH +: 32];
            ev3_reg <= ev2_reg;
            et3_reg <= et2_reg;
            t16_pipe_reg[3] <= t16_next;

            lv4_reg <= lv_next;
            lt4_reg <= lt_next;
            lvk5_reg <= lv4_reg - C_LOGK;
            ptl5_reg <= ptl_next;
            a6_reg <= a_next;
            pa7_reg <= pa_next;

            elo8_reg <= EXP_ROM[eidx];
            ed8_reg <= EXP_ROM[eidx1] - EXP_ROM[eidx];
            erem8_reg <= y[FRAC_SH-1:0];
            s8_reg <= sfull[4:0];
            sat8_reg <= ip >= 10'sd24;
            live8_reg <= ip >= -10'sd1;

            elo9_reg <= elo8_reg;
            ef9_reg <= pe[FRAC_SH +: 32];
            s9_reg <= s8_reg;
            sat9_reg <= sat8_reg;
            live9_reg <= live8_reg;

            v10_reg <= elo9_reg + ef9_reg;
            s10_reg <= s9_reg;
            sat10_reg <= sat9_reg;
            live10_reg <= live9_reg;

            for (int i = 2; i <= 10; i++) begin
                st_pipe_reg[i] <= st_pipe_reg[i-1];
            end
            for (int i = 4; i <= 10; i++) begin
                t16_pipe_reg[i] <= t16_pipe_reg[i-1];
            end

            m_temperature_reg <= $signed(t16_pipe_reg[10]);
            m_wind_speed_reg <= speed_next;
            m_status_reg <= status_next;
        end
    end

    `WSFSV_ASSERT_IMPL(a_sat_max, m_valid && m_status_reg == ST_SAT, m_wind_speed == SPEED_MAX)
    `WSFSV_ASSERT_IMPL(a_temp_zero, m_valid && m_status_reg == ST_TEMP, m_wind_speed == 24'd0)
    `WSFSV_ASSERT_IMPL(a_offs_zero, m_valid && m_status_reg == ST_OFFSET, m_wind_speed == 24'd0)
    `WSFSV_ASSERT_NEXT(a_cold_flag, s_valid && s_ready && s_vtemp_code <= 12'd200, st_pipe_reg[1] == ST_TEMP && vld_reg[0])

endmodule
`default_nettype wire

@@ sim/wind_speed_checker.sv @@
`timescale 1ns / 1ps
module wind_speed_checker
    import wsfsv_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [11:0]        s_vout_code,
    input  wire logic [11:0]        s_vtemp_code,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic signed [13:0] m_temperature,
    input  wire logic [23:0]        m_wind_speed,
    input  wire logic [1:0]         m_status,
    output int                      mismatch_count,
    output int                      pending_count
);

    typedef struct packed {
        logic [13:0] temp;
        logic [23:0] speed;
        logic [1:0]  stat;
    } reading_t;

    reading_t awaited_readings[$];
    logic [31:0] log_tab [0:TAB_N];
    logic [31:0] exp_tab [0:TAB_N];
    longint k_log1000, k_log39, k_logk;

    function automatic longint floor_shift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint exact_log2(longint unsigned x);
        longint unsigned t, m, fr;
        int e;
        e = 0;
        t = x;
        while (t > 1) begin
            t = t >> 1;
            e++;
        end
        m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
        fr = 0;
        for (int k = 0; k < 30; k++) begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        return longint'(e) * (longint'(1) << 30) + longint'(fr);
    endfunction

    function automatic longint lerp_table(bit use_exp, longint unsigned fr);
        longint unsigned idx, rem;
        longint lo, d;
        idx = (fr >> FRAC_SH) & (TAB_N - 1);
        rem = fr & ((longint'(1) << FRAC_SH) - 1);
        lo = use_exp ? longint'(exp_tab[idx]) : longint'(log_tab[idx]);
        d = (use_exp ? longint'(exp_tab[idx + 1]) : longint'(log_tab[idx + 1])) - lo;
        return lo + floor_shift(d * longint'(rem), FRAC_SH);
    endfunction

    function automatic longint table_log2(longint unsigned x);
        int e;
        longint unsigned fr;
        e = 0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                e = i;
            end
        end
        fr = (x << (30 - e)) - (longint'(1) << 30);
        return longint'(e) * (longint'(1) << 30) + lerp_table(1'b0, fr);
    endfunction

    function automatic reading_t predict_reading(logic [11:0] vo, logic [11:0] vt);
        reading_t r;
        longint n, t16, lv, lt, a, y, ip;
        longint unsigned fr, v, spd;
        int s;
        n = 64 * longint'(vt) - 12800;
        t16 = (n >= 0) ? (n + 19) / 39 : -((-n + 19) / 39);
        spd = 0;
        r.stat = ST_OK;
        if (vt <= 200) begin
            r.stat = ST_TEMP;
        end else if (2 * longint'(vo) <= 1253) begin
            r.stat = ST_OFFSET;
        end else begin
            lv = table_log2(2 * longint'(vo) - 1253) - k_log1000;
            lt = table_log2(4 * longint'(vt) - 800) - k_log39;
            a = lv - k_logk - floor_shift(lt * EXPT_Q24, 24);
            y = floor_shift(a * EXPW_Q24, 24) + 8 * (longint'(1) << 30);
            ip = floor_shift(y, 30);
            fr = y - ip * (longint'(1) << 30);
            if (ip >= 24) begin
                spd = SPEED_MAX;
                r.stat = ST_SAT;
            end else if (ip >= -1) begin
                v = lerp_table(1'b1, fr);
                s = 30 - int'(ip);
                spd = (v + (longint'(1) << (s - 1))) >> s;
                if (spd > SPEED_MAX) begin
                    spd = SPEED_MAX;
                    r.stat = ST_SAT;
                end
            end
        end
        r.temp = t16[13:0];
        r.speed = spd[23:0];
        return r;
    endfunction

    initial begin
        longint unsigned x, sum, term;
        for (int i = 0; i <= TAB_N; i++) begin
            log_tab[i] = 32'(exact_log2(TAB_N + i) - longint'(LOG_TABLE_BITS) * (longint'(1) << 30));
            x = (longint'(i) * LN2_Q30) >> LOG_TABLE_BITS;
            sum = 64'd1 << 30;
            term = 64'd1 << 30;
            for (int k = 1; k <= 24; k++) begin
                term = ((term * x) >> 30) / k;
                sum += term;
            end
            exp_tab[i] = 32'(sum);
        end
        exp_tab[TAB_N] = 32'h8000_0000;
        k_log1000 = exact_log2(64'd1000);
        k_log39 = exact_log2(64'd39);
        k_logk = exact_log2(64'd3038517) + exact_log2(64'd87288)
                 - exact_log2(64'd1000000000000);
    end

    assign pending_count = awaited_readings.size();

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && s_valid && s_ready) begin
            awaited_readings.push_back(predict_reading(s_vout_code, s_vtemp_code));
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: temp %0d speed %0d status %0d",
                             m_temperature, m_wind_speed, m_status);
                end
            end else begin
                want = awaited_readings.pop_front();
                if (want.temp !== m_temperature || want.speed !== m_wind_speed
                        || want.stat !== m_status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected temp %0d speed %0d status %0d, got %0d %0d %0d",
                                 $signed(want.temp), want.speed, want.stat,
                                 m_temperature, m_wind_speed, m_status);
                    end
                end
            end
        end
    end

endmodule

@@ sim/tb_wind_speed_from_sensor_voltages.sv @@
`timescale 1ns / 1ps
module tb_wind_speed_from_sensor_voltages;
    import wsfsv_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_REQUESTS = 1950;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [11:0] s_vout_code;
    logic [11:0] s_vtemp_code;
    logic m_valid;
    logic m_ready;
    logic signed [13:0] m_temperature;
    logic [23:0] m_wind_speed;
    logic [1:0] m_status;
    int mismatch_count;
    int pending_count;
    int idle_cycles;
    bit hold_receiver;
    bit stimulus_done;

    wind_speed_from_sensor_voltages uut (.*);
    wind_speed_checker checker_inst (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_request(logic [11:0] vo, logic [11:0] vt);
        s_valid <= 1'b1;
        s_vout_code <= vo;
        s_vtemp_code <= vt;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    initial begin
        logic [11:0] vo, vt;
        int burst;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_vout_code = '0;
        s_vtemp_code = '0;
        stimulus_done = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed corners: code extremes, the offset and temperature edges.
        send_request(12'd0, 12'd0);
        send_request(12'hFFF, 12'hFFF);
        send_request(12'hFFF, 12'd200);
        send_request(12'hFFF, 12'd201);
        send_request(12'd626, 12'd500);
        send_request(12'd627, 12'd500);
        send_request(12'd627, 12'hFFF);
        send_request(12'd628, 12'd4000);
        send_request(12'hFFF, 12'd202);
        send_request(12'd0, 12'hFFF);
        send_request(12'd700, 12'd201);
        send_request(12'd2000, 12'd1000);
        send_request(12'd1500, 12'd300);
        send_request(12'hAAA, 12'h555);
        send_request(12'h555, 12'hAAA);
        pause_sender(1);
        wait (pending_count == 0);
        @(posedge aclk);
        for (int i = 0; i < RANDOM_REQUESTS; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && i < RANDOM_REQUESTS; b++, i++) begin
                case ($urandom_range(0, 3))
                    0: vo = 12'($urandom);
                    1: vo = 12'($urandom_range(600, 700));
                    default: vo = 12'($urandom_range(627, 4095));
                endcase
                vt = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(180, 4095));
                send_request(vo, vt);
            end
            if ($urandom_range(0, 2) == 0) begin
                pause_sender($urandom_range(1, 12));
            end
            if (i == RANDOM_REQUESTS / 2) begin
                pause_sender(1);
                wait (pending_count == 0);
            end
        end
        s_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial begin
        hold_receiver = 1'b0;
        wait (aresetn === 1'b1);
        repeat (300) @(posedge aclk);
        hold_receiver = 1'b1;
        repeat (200) @(posedge aclk);
        hold_receiver = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_receiver) begin
            m_ready <= 1'b0;
        end else if (($time / 2000) % 3 == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || hold_receiver) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done);
        wait (pending_count == 0);
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
